/* src/skl_pkg.sv */
// ----------------------------------------------------------------------------
// skl_pkg
// Shared constants, codes and types for the sorted key list.
// ----------------------------------------------------------------------------
package skl_pkg;

  // number of cells in the chain
  localparam int DEPTH = 32;

  localparam int KEY_W  = 16;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;

  // index of a cell, and a count that can reach DEPTH
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LAST   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    cmp;      // capture compare flags
    logic signed [KEY_W-1:0] cmp_key;  // key to compare against
    logic                    ins;      // commit an insert
    logic                    del;      // commit a delete
    logic signed [KEY_W-1:0] new_key;  // key being inserted
  } cell_ctrl_t;

  // zero-extend or truncate a count to the position field
  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] c);
    logic [CNT_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, c};
    return wide[POS_W-1:0];
  endfunction

endpackage

/* src/skl_if.sv */
// ----------------------------------------------------------------------------
// skl_cmd_if / skl_rsp_if
// Valid/ready channels carrying command beats and response beats.
// ----------------------------------------------------------------------------
interface skl_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [skl_pkg::KIND_W-1:0]           kind;
  logic signed [skl_pkg::KEY_W-1:0]     key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

interface skl_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [skl_pkg::STAT_W-1:0]           status;
  logic signed [skl_pkg::KEY_W-1:0]     value;
  logic [skl_pkg::POS_W-1:0]            position;

  modport source (output valid, status, value, position, input ready);
  modport sink   (input valid, status, value, position, output ready);
endinterface

/* src/skl_cell.sv */
// ----------------------------------------------------------------------------
// skl_cell
// One slot of the sorted chain: holds a key and its valid flag, compares
// against the broadcast key and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module skl_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  skl_pkg::cell_ctrl_t               ctrl,
  input  logic                              left_lt,
  input  logic                              left_valid,
  input  logic signed [skl_pkg::KEY_W-1:0]  left_key,
  input  logic                              right_valid,
  input  logic signed [skl_pkg::KEY_W-1:0]  right_key,
  output logic signed [skl_pkg::KEY_W-1:0]  key,
  output logic                              valid,
  output logic                              lt,
  output logic                              eq,
  output logic                              bnd
);

  logic signed [skl_pkg::KEY_W-1:0] key_next;
  logic                             valid_next;

  // first cell whose key is not below the compare key
  assign bnd = left_lt && !lt;

  // shift in from the left on insert, from the right on delete
  always_comb begin
    key_next   = key;
    valid_next = valid;
    if (ctrl.ins) begin
      if (bnd) begin
        key_next   = ctrl.new_key;
        valid_next = 1'b1;
      end else if (!lt) begin
        key_next   = left_key;
        valid_next = left_valid;
      end
    end else if (ctrl.del && !lt) begin
      key_next   = right_key;
      valid_next = right_valid;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      valid <= valid_next;
      if (ctrl.cmp) begin
        lt <= valid && (key < ctrl.cmp_key);
        eq <= valid && (key == ctrl.cmp_key);
      end
    end
  end

  // stored key
  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

/* src/sorted_key_list.sv */
// ----------------------------------------------------------------------------
// sorted_key_list
// Ascending list of signed keys held in a chain of compare-and-shift cells;
// supports insert, delete, search, read first and read last.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                      beats
//   cmd      in   kind, key                    one per operation
//   rsp      out  status, value, position      one per cmd beat
//
// On the accepting edge every cell captures its compare flags; in the second
// step the chain shifts and the response register loads. The next command
// is taken while a response still waits. A stalled rsp holds the second
// step until the response register frees. Synchronous reset empties the
// list; stored keys are not cleared.
//
module sorted_key_list (
  input  logic             clk,
  input  logic             rst,
  skl_cmd_if.sink          cmd,
  skl_rsp_if.source        rsp
);

  localparam int DEPTH = skl_pkg::DEPTH;

  logic                              busy;
  logic [skl_pkg::KIND_W-1:0]        op_kind;
  logic signed [skl_pkg::KEY_W-1:0]  op_key;
  logic [skl_pkg::CNT_W-1:0]         entry_count;
  logic [skl_pkg::CNT_W-1:0]         entry_count_next;

  logic                              cmd_fire;
  logic                              commit;
  skl_pkg::cell_ctrl_t               ctrl;

  logic signed [skl_pkg::KEY_W-1:0]  cell_key [DEPTH];
  logic [DEPTH-1:0]                  cell_valid;
  logic [DEPTH-1:0]                  cell_lt;
  logic [DEPTH-1:0]                  cell_eq;
  logic [DEPTH-1:0]                  cell_bnd;

  logic [skl_pkg::IDX_W-1:0]         bnd_idx;
  logic                              hit;
  logic signed [skl_pkg::KEY_W-1:0]  tail_key;
  logic [skl_pkg::CNT_W-1:0]         bnd_pos;
  logic                              full;
  logic                              empty;

  logic [skl_pkg::STAT_W-1:0]        res_status;
  logic signed [skl_pkg::KEY_W-1:0]  res_value;
  logic [skl_pkg::CNT_W-1:0]         res_pos;

  // handshake
  assign cmd.ready = !busy;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign commit    = busy && (!rsp.valid || rsp.ready);

  assign full  = (entry_count == skl_pkg::CNT_W'(DEPTH));
  assign empty = (entry_count == '0);

  // broadcast to the chain
  always_comb begin
    ctrl.cmp     = cmd_fire;
    ctrl.cmp_key = cmd.key;
    ctrl.new_key = op_key;
    ctrl.ins     = commit && (op_kind == skl_pkg::KIND_INSERT) && !full;
    ctrl.del     = commit && (op_kind == skl_pkg::KIND_DELETE) && hit;
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             l_lt;
    logic                             l_valid;
    logic signed [skl_pkg::KEY_W-1:0] l_key;
    logic                             r_valid;
    logic signed [skl_pkg::KEY_W-1:0] r_key;

    if (i == 0) begin : g_head
      assign l_lt    = 1'b1;
      assign l_valid = 1'b1;
      assign l_key   = op_key;
    end else begin : g_mid
      assign l_lt    = cell_lt[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = op_key;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
    end

    skl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_lt     (l_lt),
      .left_valid  (l_valid),
      .left_key    (l_key),
      .right_valid (r_valid),
      .right_key   (r_key),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i]),
      .bnd         (cell_bnd[i])
    );
  end

  // boundary index and tail key gathered from the one-hot flags
  always_comb begin
    bnd_idx  = '0;
    tail_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_bnd[i]) begin
        bnd_idx = bnd_idx | skl_pkg::IDX_W'(i);
      end
      if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  assign hit     = |(cell_bnd & cell_eq);
  assign bnd_pos = skl_pkg::CNT_W'(bnd_idx) + skl_pkg::CNT_W'(1);

  // response fields and new count
  always_comb begin
    res_status       = skl_pkg::STAT_OK;
    res_value        = '0;
    res_pos          = '0;
    entry_count_next = entry_count;
    case (op_kind)
      skl_pkg::KIND_INSERT: begin
        if (full) begin
          res_status = skl_pkg::STAT_FULL;
        end else begin
          res_pos          = bnd_pos;
          entry_count_next = entry_count + skl_pkg::CNT_W'(1);
        end
      end
      skl_pkg::KIND_DELETE, skl_pkg::KIND_SEARCH: begin
        if (hit) begin
          res_value = op_key;
          res_pos   = bnd_pos;
          if (op_kind == skl_pkg::KIND_DELETE) begin
            entry_count_next = entry_count - skl_pkg::CNT_W'(1);
          end
        end else begin
          res_status = skl_pkg::STAT_NOT_FOUND;
        end
      end
      skl_pkg::KIND_FIRST: begin
        if (empty) begin
          res_status = skl_pkg::STAT_EMPTY;
        end else begin
          res_value = cell_key[0];
          res_pos   = skl_pkg::CNT_W'(1);
        end
      end
      skl_pkg::KIND_LAST: begin
        if (empty) begin
          res_status = skl_pkg::STAT_EMPTY;
        end else begin
          res_value = tail_key;
          res_pos   = entry_count;
        end
      end
      default: begin
        res_status = skl_pkg::STAT_OK;
      end
    endcase
  end

  // control: busy flag, count, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cmd_fire) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        entry_count <= entry_count_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid   <= 1'b0;
      end
    end
  end

  // operation and response payload
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_kind <= cmd.kind;
      op_key  <= cmd.key;
    end
    if (commit) begin
      rsp.status   <= res_status;
      rsp.value    <= res_value;
      rsp.position <= skl_pkg::to_pos(res_pos);
    end
  end

`ifndef SYNTHESIS
  // count never runs past the chain length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= skl_pkg::CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // occupied cells always match the count
  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(entry_count))
    else $error("valid cells disagree with entry count");

  // at most one insertion point along the chain
  a_bnd_onehot: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(cell_bnd))
    else $error("more than one boundary cell");

  // an accepted beat always produces a response on its commit
  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp.valid && !busy)
    else $error("commit without response");
`endif

endmodule
